@@ rtl/well512_random_generator_core_macros.svh @@
// Assertion macros shared by the well512 generator RTL.
// No dependencies; the assertion forms collapse to nothing when ASSERT_OFF is set.
`ifndef WELL512_RANDOM_GENERATOR_CORE_MACROS_SVH
`define WELL512_RANDOM_GENERATOR_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define WRG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("well512 core assertion failed");
`define WRG_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("well512 core forbidden condition seen");
`else
`define WRG_ASSERT(lbl, clk, rst_n, prop)
`define WRG_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ rtl/wrg_pkg.sv @@
// Types and constants of the well512 generator core.
// No dependencies; used by the remainder unit and the top level.
package wrg_pkg;

	localparam int WORD_W = 32;
	localparam int PTR_W  = 4;

	localparam logic [WORD_W-1:0] SEED_MULT   = 32'd1812433253;
	localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA442D24;
	localparam logic [WORD_W-1:0] SEED_RESET  = 32'd1;
	localparam logic [WORD_W-1:0] BOUND_ALL   = 32'hFFFFFFFF;

	localparam logic [PTR_W-1:0] OFS_C13 = 4'd13;
	localparam logic [PTR_W-1:0] OFS_C9  = 4'd9;
	localparam logic [PTR_W-1:0] OFS_Q   = 4'd15;
	localparam logic [PTR_W-1:0] LAST_IX = 4'd15;

	localparam logic CMD_DRAW   = 1'b0;
	localparam logic CMD_RESEED = 1'b1;

	typedef enum logic [3:0] {
		ST_FILL,
		ST_IDLE,
		ST_RD_A,
		ST_RD_C13,
		ST_RD_C9,
		ST_RD_Q,
		ST_UPD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

@@ rtl/wrg_ram.sv @@
// Generic single write port, single read port RAM with a registered read.
// No dependencies.
module wrg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/wrg_rem.sv @@
// Restoring remainder unit, one dividend bit per cycle.
// Depends on wrg_pkg.
module wrg_rem (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [wrg_pkg::WORD_W-1:0]   dividend,
	input  logic [wrg_pkg::WORD_W-1:0]   divisor,
	output logic [wrg_pkg::WORD_W-1:0]   rem,
	output wrg_pkg::div_sts_t            sts
);

	localparam int CNT_W = $clog2(wrg_pkg::WORD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(wrg_pkg::WORD_W - 1);

	logic                       busy_q;
	logic                       done_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [wrg_pkg::WORD_W-1:0] rem_q;
	logic [wrg_pkg::WORD_W-1:0] dvd_q;
	logic [wrg_pkg::WORD_W-1:0] dvs_q;
	logic [wrg_pkg::WORD_W:0]   trial;
	logic [wrg_pkg::WORD_W:0]   diff;

	assign trial = {rem_q, dvd_q[wrg_pkg::WORD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[wrg_pkg::WORD_W-2:0], 1'b0};
			if (!diff[wrg_pkg::WORD_W]) begin
				rem_q <= diff[wrg_pkg::WORD_W-1:0];
			end else begin
				rem_q <= trial[wrg_pkg::WORD_W-1:0];
			end
		end
	end

	assign rem      = rem_q;
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

@@ rtl/well512_random_generator_core.sv @@
// Top level of the WELL512a generator: control, state memory and output register.
// Depends on wrg_pkg, wrg_ram, wrg_rem and the assertion macro header.
//
// The sixteen state words live in a 16 x 32 RAM with a registered read, so a draw first does
// its memory traffic in ST_RD_A, ST_RD_C13, ST_RD_C9, ST_RD_Q and ST_UPD (four reads, two
// write-backs) and then, unless bound is all ones, a remainder by bound plus one in a
// one-bit-per-cycle restoring unit. A reseed request writes one word per cycle through a
// single 32-bit multiplier, with no result. After reset the same fill runs from seed 1
// before the first request is taken; seed writes are taken at any time. One request is
// worked on at a time, and a new request is taken while a finished result still waits in
// the output register.
`include "well512_random_generator_core_macros.svh"

module well512_random_generator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_wr_en,
	input  logic [31:0] seed_wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [31:0] bound,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] raw_value,
	output logic [31:0] bounded_value
);

	wrg_pkg::state_t            state_q;
	wrg_pkg::state_t            state_d;
	logic [wrg_pkg::PTR_W-1:0]  ptr_q;
	logic [wrg_pkg::PTR_W-1:0]  cnt_q;
	logic [wrg_pkg::WORD_W-1:0] seed_q;
	logic [wrg_pkg::WORD_W-1:0] prev_q;
	logic [wrg_pkg::WORD_W-1:0] bound_q;
	logic [wrg_pkg::WORD_W-1:0] a_q;
	logic [wrg_pkg::WORD_W-1:0] b_q;
	logic [wrg_pkg::WORD_W-1:0] c_q;
	logic [wrg_pkg::WORD_W-1:0] d_q;
	logic [wrg_pkg::WORD_W-1:0] raw_q;
	logic [wrg_pkg::WORD_W-1:0] bnd_q;
	logic                       out_valid_q;
	logic [wrg_pkg::WORD_W-1:0] raw_value_q;
	logic [wrg_pkg::WORD_W-1:0] bounded_value_q;

	logic                       ram_we;
	logic [wrg_pkg::PTR_W-1:0]  ram_waddr;
	logic [wrg_pkg::WORD_W-1:0] ram_wdata;
	logic [wrg_pkg::PTR_W-1:0]  ram_raddr;
	logic [wrg_pkg::WORD_W-1:0] ram_rdata;

	logic                       accept;
	logic                       out_free;
	logic                       bound_all;
	logic                       div_start;
	logic [wrg_pkg::WORD_W-1:0] div_rem;
	wrg_pkg::div_sts_t          div_sts;
	logic                       st_done;
	logic                       ptr_step;

	logic [wrg_pkg::WORD_W-1:0] fill_mix;
	logic [wrg_pkg::WORD_W-1:0] fill_word;
	logic [wrg_pkg::WORD_W-1:0] c_mix;
	logic [wrg_pkg::WORD_W-1:0] a_new;
	logic [wrg_pkg::WORD_W-1:0] r_new;

	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign bound_all = (bound_q == wrg_pkg::BOUND_ALL);
	assign st_done   = (state_q == wrg_pkg::ST_DONE);
	assign ptr_step  = (state_q == wrg_pkg::ST_UPD) || (state_q == wrg_pkg::ST_FILL);

	assign fill_mix  = prev_q ^ (prev_q >> 30);
	assign fill_word = (cnt_q == '0) ? seed_q
		: (wrg_pkg::SEED_MULT * fill_mix) + {{(wrg_pkg::WORD_W-wrg_pkg::PTR_W){1'b0}}, cnt_q};

	assign c_mix = ram_rdata ^ (ram_rdata >> 11);
	assign a_new = b_q ^ c_mix;
	assign r_new = ram_rdata ^ b_q ^ d_q ^ (ram_rdata << 2) ^ (b_q << 18) ^ (c_q << 28);

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = ptr_q;
		ram_wdata = a_new;
		ram_raddr = ptr_q;
		div_start = 1'b0;
		case (state_q)
			wrg_pkg::ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = fill_word;
				if (cnt_q == wrg_pkg::LAST_IX) begin
					state_d = wrg_pkg::ST_IDLE;
				end
			end
			wrg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = (cmd == wrg_pkg::CMD_RESEED) ? wrg_pkg::ST_FILL : wrg_pkg::ST_RD_A;
				end
			end
			wrg_pkg::ST_RD_A: begin
				ram_raddr = ptr_q;
				state_d   = wrg_pkg::ST_RD_C13;
			end
			wrg_pkg::ST_RD_C13: begin
				ram_raddr = ptr_q + wrg_pkg::OFS_C13;
				state_d   = wrg_pkg::ST_RD_C9;
			end
			wrg_pkg::ST_RD_C9: begin
				ram_raddr = ptr_q + wrg_pkg::OFS_C9;
				state_d   = wrg_pkg::ST_RD_Q;
			end
			wrg_pkg::ST_RD_Q: begin
				ram_raddr = ptr_q + wrg_pkg::OFS_Q;
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = a_new;
				state_d   = wrg_pkg::ST_UPD;
			end
			wrg_pkg::ST_UPD: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q + wrg_pkg::OFS_Q;
				ram_wdata = r_new;
				if (bound_all) begin
					state_d = wrg_pkg::ST_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = wrg_pkg::ST_DIV;
				end
			end
			wrg_pkg::ST_DIV: begin
				if (div_sts.done) begin
					state_d = wrg_pkg::ST_DONE;
				end
			end
			wrg_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = wrg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wrg_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wrg_pkg::ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= wrg_pkg::SEED_RESET;
			ptr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_wr_en) begin
				seed_q <= seed_wr_data;
			end
			if (state_q == wrg_pkg::ST_FILL) begin
				cnt_q <= cnt_q + 1'b1;
				ptr_q <= '0;
			end else if (accept) begin
				cnt_q <= '0;
			end
			if (state_q == wrg_pkg::ST_UPD) begin
				ptr_q <= ptr_q + wrg_pkg::OFS_Q;
			end
			if (state_q == wrg_pkg::ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == wrg_pkg::ST_FILL) begin
			prev_q <= fill_word;
		end
		if (accept) begin
			bound_q <= bound;
		end
		if (state_q == wrg_pkg::ST_RD_C13) begin
			a_q <= ram_rdata;
		end
		if (state_q == wrg_pkg::ST_RD_C9) begin
			b_q <= a_q ^ ram_rdata ^ (a_q << 16) ^ (ram_rdata << 15);
		end
		if (state_q == wrg_pkg::ST_RD_Q) begin
			c_q <= c_mix;
			d_q <= a_new ^ ((a_new << 5) & wrg_pkg::TEMPER_MASK);
		end
		if (state_q == wrg_pkg::ST_UPD) begin
			raw_q <= r_new;
			bnd_q <= r_new;
		end
		if (state_q == wrg_pkg::ST_DIV && div_sts.done) begin
			bnd_q <= div_rem;
		end
		if (state_q == wrg_pkg::ST_DONE && out_free) begin
			raw_value_q     <= raw_q;
			bounded_value_q <= bnd_q;
		end
	end

	wrg_ram #(
		.WIDTH(wrg_pkg::WORD_W),
		.DEPTH(16)
	) u_pool (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	wrg_rem u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(r_new),
		.divisor (bound_q + 32'd1),
		.rem     (div_rem),
		.sts     (div_sts)
	);

	assign out_valid     = out_valid_q;
	assign raw_value     = raw_value_q;
	assign bounded_value = bounded_value_q;

	`WRG_ASSERT(a_out_from_done, clk, arst_n, $rose(out_valid_q) |-> $past(st_done))
	`WRG_ASSERT_NEVER(a_no_write_idle, clk, arst_n, (state_q == wrg_pkg::ST_IDLE) && ram_we)
	`WRG_ASSERT(a_div_done_in_div, clk, arst_n, div_sts.done |-> (state_q == wrg_pkg::ST_DIV))
	`WRG_ASSERT(a_ptr_moves_on_update, clk, arst_n, !$stable(ptr_q) |-> $past(ptr_step))

endmodule
